// ===== hdl/i2cms_pkg.sv =====
`default_nettype none

package i2cms_pkg;

    // Default width of the transfer byte counters.
    localparam int unsigned COUNT_BITS_DEF = 16;

    // Largest number of bytes in one chunk.
    localparam logic [7:0] CHUNK_MAX = 8'hFF;

    // Item kinds.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_EVENT = 2'd1;
    localparam logic [1:0] MODE_ERROR = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    // Bit positions in the status flags.
    localparam int unsigned FLAG_NACK   = 0;
    localparam int unsigned FLAG_RELOAD = 1;
    localparam int unsigned FLAG_RXNE   = 2;
    localparam int unsigned FLAG_TXE    = 3;
    localparam int unsigned FLAG_STOP   = 4;
    localparam int unsigned FLAG_TC     = 5;
    localparam int unsigned FLAG_BUSY   = 6;
    localparam int unsigned FLAG_OVR    = 7;
    localparam int unsigned FLAG_BERR   = 8;
    localparam int unsigned FLAG_ARLO   = 9;

    // Sticky error masks.
    localparam logic [4:0] ERR_NACK = 5'b00001;
    localparam logic [4:0] ERR_BERR = 5'b00010;
    localparam logic [4:0] ERR_ARLO = 5'b00100;
    localparam logic [4:0] ERR_OVR  = 5'b01000;
    localparam logic [4:0] ERR_LOCK = 5'b10000;

    // Completion codes.
    localparam logic [1:0] DONE_RUN  = 2'd0;
    localparam logic [1:0] DONE_OK   = 2'd1;
    localparam logic [1:0] DONE_FAIL = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic        is_read;
        logic [15:0] total_bytes;
        logic        stop_wanted;
        logic [6:0]  target_address;
        logic [9:0]  status_flags;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } t_in_item;

    typedef struct packed {
        logic        start_cmd;
        logic        stop_cmd;
        logic        auto_end;
        logic        read_dir;
        logic [6:0]  address_out;
        logic        chunk_reload;
        logic [7:0]  chunk_bytes;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [1:0]  done_status;
        logic [4:0]  error_bits;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/i2cms_stream_if.sv =====
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface i2cms_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2cms_engine.sv =====
`default_nettype none

module i2cms_engine #(
    parameter int unsigned COUNT_BITS = i2cms_pkg::COUNT_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  i2cms_pkg::t_in_item   i_item,
    output i2cms_pkg::t_out_item  o_result
);
    import i2cms_pkg::*;

    // Transfer state.
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_stop_at_end, n_stop_at_end;
    logic                  r_restart, n_restart;
    logic [4:0]            r_sticky, n_sticky;
    logic                  r_fault, n_fault;
    logic                  r_active, n_active;

    // Chunk sizing for a new transfer and for a reload.
    logic [COUNT_BITS-1:0] start_total;
    logic [COUNT_BITS-1:0] left_cur;
    logic                  start_big;
    logic                  cur_big;
    logic [7:0]            start_chunk;
    logic [7:0]            cur_chunk;

    // Byte movement on an event.
    logic [9:0]            fl;
    logic                  byte_move;
    logic [COUNT_BITS-1:0] count_nxt;
    logic                  short_xfer;
    logic                  fault_now;

    t_out_item res;

    assign fl          = i_item.status_flags;
    assign start_total = COUNT_BITS'(i_item.total_bytes);
    assign left_cur    = r_total - r_count;
    assign start_big   = |start_total[COUNT_BITS-1:8];
    assign cur_big     = |left_cur[COUNT_BITS-1:8];
    assign start_chunk = start_big ? CHUNK_MAX : start_total[7:0];
    assign cur_chunk   = cur_big ? CHUNK_MAX : left_cur[7:0];

    assign byte_move  = (r_count < r_total) && (fl[FLAG_RXNE] || fl[FLAG_TXE]);
    assign count_nxt  = byte_move ? (r_count + COUNT_BITS'(1)) : r_count;
    assign short_xfer = count_nxt < r_total;
    assign fault_now  = r_fault || short_xfer;

    // Next state and result for the current item.
    always_comb begin
        n_total       = r_total;
        n_count       = r_count;
        n_stop_at_end = r_stop_at_end;
        n_restart     = r_restart;
        n_sticky      = r_sticky;
        n_fault       = r_fault;
        n_active      = r_active;
        res           = '0;

        unique case (i_item.mode)
            MODE_START: begin
                if (!r_active) begin
                    if ((r_sticky & ERR_LOCK) != '0) begin
                        n_restart       = 1'b0;
                        res.done_status = DONE_FAIL;
                    end else if (!r_restart && fl[FLAG_BUSY]) begin
                        n_sticky        = ERR_LOCK;
                        res.done_status = DONE_FAIL;
                    end else begin
                        // A restart keeps the address already on the bus.
                        if (!r_restart) begin
                            res.address_out = i_item.target_address;
                        end
                        n_total          = start_total;
                        n_count          = '0;
                        n_stop_at_end    = i_item.stop_wanted;
                        n_restart        = 1'b0;
                        n_fault          = 1'b0;
                        n_active         = 1'b1;
                        res.chunk_reload = start_big;
                        res.chunk_bytes  = start_chunk;
                        res.start_cmd    = 1'b1;
                        res.auto_end     = i_item.stop_wanted;
                        res.read_dir     = i_item.is_read;
                    end
                end
            end
            MODE_EVENT: begin
                if (r_active) begin
                    if (fl[FLAG_NACK]) begin
                        n_sticky        = r_sticky | ERR_NACK;
                        n_fault         = 1'b0;
                        n_active        = 1'b0;
                        res.done_status = DONE_FAIL;
                    end else begin
                        if (fl[FLAG_RELOAD]) begin
                            res.chunk_reload = cur_big;
                            res.chunk_bytes  = cur_chunk;
                        end
                        if (byte_move) begin
                            res.data_valid = 1'b1;
                            res.data_byte  = fl[FLAG_RXNE] ? i_item.rx_byte : i_item.tx_byte;
                        end
                        n_count = count_nxt;
                        if (fl[FLAG_STOP]) begin
                            // A stop before the last byte is a bus error.
                            n_active = 1'b0;
                            n_fault  = 1'b0;
                            if (fault_now) begin
                                n_sticky        = short_xfer ? (r_sticky | ERR_BERR) : r_sticky;
                                res.done_status = DONE_FAIL;
                            end else begin
                                n_sticky        = '0;
                                res.done_status = DONE_OK;
                            end
                        end else if (fl[FLAG_TC] && !short_xfer) begin
                            if (r_stop_at_end) begin
                                res.stop_cmd = 1'b1;
                            end else begin
                                n_restart = 1'b1;
                                n_active  = 1'b0;
                                n_fault   = 1'b0;
                                if (r_fault) begin
                                    res.done_status = DONE_FAIL;
                                end else begin
                                    n_sticky        = '0;
                                    res.done_status = DONE_OK;
                                end
                            end
                        end
                    end
                end
            end
            MODE_ERROR: begin
                if (r_active) begin
                    n_sticky = r_sticky
                             | (fl[FLAG_OVR]  ? ERR_OVR  : '0)
                             | (fl[FLAG_BERR] ? ERR_BERR : '0)
                             | (fl[FLAG_ARLO] ? ERR_ARLO : '0);
                    n_fault         = 1'b0;
                    n_active        = 1'b0;
                    res.done_status = DONE_FAIL;
                end
            end
            MODE_FLUSH: begin
                if (((r_sticky & (ERR_LOCK | ERR_BERR)) != '0) && fl[FLAG_BUSY]) begin
                    n_sticky = '0;
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase

        res.error_bits = n_sticky;
    end

    assign o_result = res;

    // State update, one item per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total       <= '0;
            r_count       <= '0;
            r_stop_at_end <= 1'b0;
            r_restart     <= 1'b0;
            r_sticky      <= '0;
            r_fault       <= 1'b0;
            r_active      <= 1'b0;
        end else if (i_en) begin
            r_total       <= n_total;
            r_count       <= n_count;
            r_stop_at_end <= n_stop_at_end;
            r_restart     <= n_restart;
            r_sticky      <= n_sticky;
            r_fault       <= n_fault;
            r_active      <= n_active;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_transfer_sequencer.sv =====
// I2C master transfer sequencer. Each transaction on i_in is one start, bus
// event, error interrupt or flush item, and each produces exactly one result
// transaction on o_out carrying the bus commands, the chunk programming, the
// moved data byte, the completion code and the sticky error bits. The block
// takes one item per clock cycle while o_out is ready. A result reaches o_out
// after the input register and the result register: the item waits in the
// input register while the transfer state update loads the result register.
// Results stall when o_out is not ready, and i_in keeps taking items until
// both registers are full. There is no configuration and no clearing pass
// after reset. COUNT_BITS sets the width of the byte counters (9 to 32).
`default_nettype none

module i2c_master_transfer_sequencer #(
    parameter int unsigned COUNT_BITS = i2cms_pkg::COUNT_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    i2cms_stream_if.sink   i_in,
    i2cms_stream_if.source o_out
);
    import i2cms_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      s1_adv;

    // The held item moves on when the result register is free or draining.
    assign s1_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s1_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    i2cms_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s1_adv),
        .i_item   (r_in_item),
        .o_result (n_out_item)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

`ifndef SYNTHESIS
    // An accepted item is held in the input register on the next cycle.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_valid)
        else $error("accepted item was not captured");

    // A start command never comes with a completion code.
    a_start_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.start_cmd) |-> (r_out_item.done_status == DONE_RUN))
        else $error("start command reported a completion");

    // A chunk followed by more chunks is always full.
    a_reload_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.chunk_reload) |-> (r_out_item.chunk_bytes == CHUNK_MAX))
        else $error("reload chunk is not full");

    // A successful completion leaves no sticky errors.
    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_item.done_status == DONE_OK)) |-> (r_out_item.error_bits == '0))
        else $error("successful transfer kept sticky errors");
`endif

endmodule

`default_nettype wire

// ===== verif/i2cms_transfer_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the transfer sequencer. It predicts one result per
// accepted input transaction and compares every accepted result, field by
// field, with the oldest prediction still waiting.
module i2cms_transfer_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  i2cms_pkg::t_in_item  i_in_item,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  i2cms_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);
    import i2cms_pkg::*;

    localparam int unsigned CW = COUNT_BITS_DEF;

    // Shadow copy of the transfer state.
    logic          xfer_active;
    logic [CW-1:0] xfer_total;
    logic [CW-1:0] xfer_count;
    logic          xfer_stop;
    logic          restart_due;
    logic          fault_seen;
    logic [4:0]    sticky_errs;

    t_out_item results_due[$];

    // Chunk that is programmed for the bytes still left: {reload, bytes}.
    function automatic logic [8:0] chunk_plan();
        logic [CW-1:0] left;
        left = xfer_total - xfer_count;
        if (left <= CW'(CHUNK_MAX)) begin
            return {1'b0, left[7:0]};
        end
        return {1'b1, CHUNK_MAX};
    endfunction

    // Ends the transfer; errors stay sticky only when it failed.
    function automatic logic [1:0] close_transfer();
        xfer_active = 1'b0;
        if (fault_seen) begin
            fault_seen = 1'b0;
            return DONE_FAIL;
        end
        sticky_errs = '0;
        return DONE_OK;
    endfunction

    // Result of one input transaction, updating the shadow state.
    function automatic t_out_item transfer_step(input t_in_item it);
        t_out_item  r;
        logic [9:0] fl;
        r  = '0;
        fl = it.status_flags;
        case (it.mode)
            MODE_START: begin
                if (!xfer_active) begin
                    if ((sticky_errs & ERR_LOCK) != '0) begin
                        restart_due   = 1'b0;
                        r.done_status = DONE_FAIL;
                    end else if (!restart_due && fl[FLAG_BUSY]) begin
                        sticky_errs   = ERR_LOCK;
                        r.done_status = DONE_FAIL;
                    end else begin
                        // A restart keeps the address of the previous transfer.
                        if (!restart_due) begin
                            r.address_out = it.target_address;
                        end
                        xfer_total  = CW'(it.total_bytes);
                        xfer_count  = '0;
                        xfer_stop   = it.stop_wanted;
                        restart_due = 1'b0;
                        fault_seen  = 1'b0;
                        xfer_active = 1'b1;
                        {r.chunk_reload, r.chunk_bytes} = chunk_plan();
                        r.start_cmd = 1'b1;
                        r.auto_end  = xfer_stop;
                        r.read_dir  = it.is_read;
                    end
                end
            end
            MODE_EVENT: begin
                if (xfer_active) begin
                    if (fl[FLAG_NACK]) begin
                        fault_seen    = 1'b1;
                        sticky_errs   = sticky_errs | ERR_NACK;
                        r.done_status = close_transfer();
                    end else begin
                        if (fl[FLAG_RELOAD]) begin
                            {r.chunk_reload, r.chunk_bytes} = chunk_plan();
                        end
                        // The receive side wins when both data flags are set.
                        if (xfer_count < xfer_total && (fl[FLAG_RXNE] || fl[FLAG_TXE])) begin
                            r.data_valid = 1'b1;
                            r.data_byte  = fl[FLAG_RXNE] ? it.rx_byte : it.tx_byte;
                            xfer_count   = xfer_count + 1'b1;
                        end
                        if (fl[FLAG_STOP]) begin
                            if (xfer_count < xfer_total) begin
                                fault_seen  = 1'b1;
                                sticky_errs = sticky_errs | ERR_BERR;
                            end
                            r.done_status = close_transfer();
                        end else if (fl[FLAG_TC] && xfer_count >= xfer_total) begin
                            if (xfer_stop) begin
                                r.stop_cmd = 1'b1;
                            end else begin
                                restart_due   = 1'b1;
                                r.done_status = close_transfer();
                            end
                        end
                    end
                end
            end
            MODE_ERROR: begin
                if (xfer_active) begin
                    fault_seen = 1'b1;
                    if (fl[FLAG_OVR]) sticky_errs = sticky_errs | ERR_OVR;
                    if (fl[FLAG_BERR]) sticky_errs = sticky_errs | ERR_BERR;
                    if (fl[FLAG_ARLO]) sticky_errs = sticky_errs | ERR_ARLO;
                    r.done_status = close_transfer();
                end
            end
            default: begin
                if ((sticky_errs & (ERR_LOCK | ERR_BERR)) != '0 && fl[FLAG_BUSY]) begin
                    sticky_errs = '0;
                end
            end
        endcase
        r.error_bits = sticky_errs;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    task automatic compare_result(input t_out_item want, input t_out_item got);
        check_field("start_cmd", 8'(want.start_cmd), 8'(got.start_cmd));
        check_field("stop_cmd", 8'(want.stop_cmd), 8'(got.stop_cmd));
        check_field("auto_end", 8'(want.auto_end), 8'(got.auto_end));
        check_field("read_dir", 8'(want.read_dir), 8'(got.read_dir));
        check_field("address_out", 8'(want.address_out), 8'(got.address_out));
        check_field("chunk_reload", 8'(want.chunk_reload), 8'(got.chunk_reload));
        check_field("chunk_bytes", want.chunk_bytes, got.chunk_bytes);
        check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("done_status", 8'(want.done_status), 8'(got.done_status));
        check_field("error_bits", 8'(want.error_bits), 8'(got.error_bits));
    endtask

    // Predict on each input transaction, compare on each result transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            xfer_active = 1'b0;
            xfer_total  = '0;
            xfer_count  = '0;
            xfer_stop   = 1'b0;
            restart_due = 1'b0;
            fault_seen  = 1'b0;
            sticky_errs = '0;
            results_due.delete();
        end else begin
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                results_due.push_back(transfer_step(i_in_item));
            end
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with nothing expected, expected none, actual %0h",
                             $time, i_out_item);
                end else begin
                    compare_result(results_due.pop_front(), i_out_item);
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== verif/i2c_master_transfer_sequencer_test.sv =====
`timescale 1ns / 100ps

// Drives start, event, error and flush transactions into the sequencer and
// gives the verdict; prediction and comparison live in the checker.
module i2c_master_transfer_sequencer_test;
    import i2cms_pkg::*;

    localparam int ITEM_GOAL   = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 19;

    localparam logic [9:0] BIT_NACK   = 10'd1 << FLAG_NACK;
    localparam logic [9:0] BIT_RELOAD = 10'd1 << FLAG_RELOAD;
    localparam logic [9:0] BIT_RX     = 10'd1 << FLAG_RXNE;
    localparam logic [9:0] BIT_TX     = 10'd1 << FLAG_TXE;
    localparam logic [9:0] BIT_STOP   = 10'd1 << FLAG_STOP;
    localparam logic [9:0] BIT_TC     = 10'd1 << FLAG_TC;
    localparam logic [9:0] BIT_BUSY   = 10'd1 << FLAG_BUSY;
    localparam logic [9:0] BIT_OVR    = 10'd1 << FLAG_OVR;
    localparam logic [9:0] BIT_BERR   = 10'd1 << FLAG_BERR;
    localparam logic [9:0] BIT_ARLO   = 10'd1 << FLAG_ARLO;

    logic i_clk;
    logic i_rst_n = 1'b0;

    int  fail_count;
    int  pending;
    int  items_sent;
    int  sink_hold;
    int  cycles;
    bit  idle_on;

    i2cms_stream_if #(.t_payload(t_in_item))  in_if ();
    i2cms_stream_if #(.t_payload(t_out_item)) out_if ();

    i2c_master_transfer_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    i2cms_transfer_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_item    (in_if.payload),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_item   (out_if.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Run limit.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("i2c_master_transfer_sequencer_test: done, errors");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                out_if.ready <= 1'b0;
                sink_hold--;
            end else if (idle_on) begin
                out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Item with random content in the fields that the kind does not use.
    function automatic t_in_item make_item(input logic [1:0] kind, input logic [9:0] flags);
        t_in_item it;
        it.mode           = kind;
        it.is_read        = 1'($urandom);
        it.total_bytes    = 16'($urandom);
        it.stop_wanted    = 1'($urandom);
        it.target_address = 7'($urandom);
        it.status_flags   = flags;
        it.rx_byte        = 8'($urandom);
        it.tx_byte        = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item start_item(input logic rd, input logic [15:0] total,
                                            input logic stop_end, input logic [6:0] addr,
                                            input logic [9:0] flags);
        t_in_item it;
        it                = make_item(MODE_START, flags);
        it.is_read        = rd;
        it.total_bytes    = total;
        it.stop_wanted    = stop_end;
        it.target_address = addr;
        return it;
    endfunction

    // One transaction on the input channel, with random gaps before it.
    task automatic offer(input t_in_item it);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait (pending == 0);
    endtask

    // A well-formed transfer: start, one event per byte, then completion and, if
    // stop_end is set, stop; optionally cut short by a NACK, an error interrupt or an early stop.
    task automatic run_transfer(input int unsigned nbytes, input logic rd,
                                input logic stop_end, input bit with_fault);
        t_in_item    it;
        logic [9:0]  fl;
        int unsigned fault_at;
        int unsigned idx;
        bit          tc_sent;
        fl = ($urandom_range(0, 15) == 0) ? BIT_BUSY : '0;
        offer(start_item(rd, 16'(nbytes), stop_end, 7'($urandom), fl));
        fault_at = with_fault ? $urandom_range(0, nbytes) : nbytes + 1;
        tc_sent  = 1'b0;
        for (idx = 0; idx < nbytes; idx++) begin
            if (idx == fault_at) break;
            fl = rd ? BIT_RX : BIT_TX;
            if ($urandom_range(0, 15) == 0) fl = fl | BIT_RX | BIT_TX;
            if (idx != 0 && idx % 255 == 0) fl = fl | BIT_RELOAD;
            if (idx == nbytes - 1 && $urandom_range(0, 2) == 0) begin
                fl      = fl | BIT_TC;
                tc_sent = 1'b1;
            end
            offer(make_item(MODE_EVENT, fl));
        end
        if (fault_at <= nbytes) begin
            case ($urandom_range(0, 2))
                0: offer(make_item(MODE_EVENT, BIT_NACK | 10'($urandom_range(0, 3) << 2)));
                1: offer(make_item(MODE_ERROR, 10'($urandom)));
                default: offer(make_item(MODE_EVENT, BIT_STOP));
            endcase
        end else begin
            if (!tc_sent) offer(make_item(MODE_EVENT, BIT_TC));
            if (stop_end) offer(make_item(MODE_EVENT, BIT_STOP));
        end
    endtask

    // Stimulus.
    initial begin
        t_in_item    it;
        int unsigned roll;
        int unsigned nbytes;
        bit          held;
        bit          paused;

        in_if.valid   = 1'b0;
        in_if.payload = '0;
        idle_on       = 1'b1;
        sink_hold     = 0;
        items_sent    = 0;
        held          = 1'b0;
        paused        = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        offer(make_item(MODE_FLUSH, '0));                       // nothing to clear
        offer(make_item(MODE_EVENT, BIT_RX | BIT_TC));          // event while idle
        offer(make_item(MODE_ERROR, BIT_OVR | BIT_BERR | BIT_ARLO));
        offer(start_item(1'b1, 16'hFFFF, 1'b1, 7'h7F, 10'h3FF)); // busy bus locks
        offer(start_item(1'b0, 16'd1, 1'b1, 7'h55, '0));        // refused while locked
        offer(make_item(MODE_FLUSH, BIT_BUSY));                 // lock cleared
        offer(start_item(1'b1, 16'hFFFF, 1'b1, 7'h7F, '0));     // largest transfer
        offer(start_item(1'b0, 16'd4, 1'b0, 7'h01, '0));        // ignored while active
        it         = make_item(MODE_EVENT, BIT_RX | BIT_TX);    // receive side wins
        it.rx_byte = 8'hFF;
        it.tx_byte = 8'h00;
        offer(it);
        offer(make_item(MODE_EVENT, BIT_RELOAD | BIT_TX));
        offer(make_item(MODE_ERROR, BIT_OVR | BIT_BERR | BIT_ARLO));
        offer(make_item(MODE_FLUSH, BIT_BUSY));                 // bus error cleared
        offer(start_item(1'b0, 16'd0, 1'b0, 7'h00, '0));        // zero bytes, no stop
        offer(make_item(MODE_EVENT, BIT_TX));                   // past the total
        offer(make_item(MODE_EVENT, BIT_TC));                   // leaves a restart
        offer(start_item(1'b0, 16'd1, 1'b1, 7'h2A, BIT_BUSY));  // restart skips bus check
        it         = make_item(MODE_EVENT, BIT_TX);
        it.tx_byte = 8'hA5;
        offer(it);
        offer(make_item(MODE_EVENT, BIT_TC));                   // stop command
        offer(make_item(MODE_EVENT, BIT_STOP));
        offer(start_item(1'b1, 16'd3, 1'b1, 7'h33, '0));
        offer(make_item(MODE_EVENT, BIT_RX));
        offer(make_item(MODE_EVENT, BIT_STOP));                 // stop too early
        offer(start_item(1'b0, 16'd2, 1'b1, 7'h44, '0));
        offer(make_item(MODE_EVENT, BIT_NACK));
        settle();

        // Random part: mostly well-formed transfers, some noise and flushes.
        while (items_sent < ITEM_GOAL) begin
            idle_on = (items_sent < 380) || (items_sent >= 560);
            if (!held && items_sent >= 300) begin
                held      = 1'b1;
                sink_hold = 120;
            end
            if (!paused && items_sent >= 500) begin
                paused = 1'b1;
                settle();
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                it = make_item(2'($urandom_range(0, 3)), 10'($urandom));
                if ($urandom_range(0, 3) != 0) it.total_bytes = 16'($urandom_range(0, 15));
                offer(it);
            end else if (roll < 14) begin
                offer(make_item(MODE_FLUSH, $urandom_range(0, 1) ? BIT_BUSY : 10'($urandom)));
            end else begin
                nbytes = ($urandom_range(0, 59) == 0) ? $urandom_range(256, 520)
                                                      : $urandom_range(0, 12);
                run_transfer(nbytes, 1'($urandom), 1'($urandom), $urandom_range(0, 7) == 0);
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("i2c_master_transfer_sequencer_test: done, clean");
        end else begin
            $display("i2c_master_transfer_sequencer_test: done, errors");
        end
        $finish;
    end

endmodule
